>>> design/assert_macros.svh
// Assertion macros shared by the hasher RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/shb_pkg.sv
// Shared types, constants and SHA-256 helper functions for the byte stream hasher.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package shb_pkg;

  localparam int WORD_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int BLOCK_W  = 512;
  localparam int FILL_W   = 6;
  localparam int LEN_W    = 61;
  localparam int ROUND_W  = 6;
  localparam int WIDX_W   = 3;
  localparam int N_HASH   = 8;

  localparam logic [BYTE_W-1:0] PAD_MARK   = 8'h80;
  localparam logic [FILL_W-1:0] LEN_START  = 6'd56;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_OUT
  } shb_state_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WORD_W-1:0] sml_sig0(input logic [WORD_W-1:0] x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] sml_sig1(input logic [WORD_W-1:0] x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Initial hash values
  function automatic logic [WORD_W-1:0] iv_word(input logic [WIDX_W-1:0] idx);
    case (idx)
      3'd0:    iv_word = 32'h6a09e667;
      3'd1:    iv_word = 32'hbb67ae85;
      3'd2:    iv_word = 32'h3c6ef372;
      3'd3:    iv_word = 32'ha54ff53a;
      3'd4:    iv_word = 32'h510e527f;
      3'd5:    iv_word = 32'h9b05688c;
      3'd6:    iv_word = 32'h1f83d9ab;
      3'd7:    iv_word = 32'h5be0cd19;
      default: iv_word = '0;
    endcase
  endfunction

  // Round constants
  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = '0;
    endcase
  endfunction

endpackage

>>> design/shb_if.sv
// Valid/ready channel interfaces for the hasher: message bytes in, digest words out.
// Payload widths come from the fixed field widths in shb_pkg.
`timescale 1ns / 1ps

interface shb_in_if;
  import shb_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   message_byte;
  logic                byte_present;
  logic                message_end;

  modport source (output valid, message_byte, byte_present, message_end, input ready);
  modport sink   (input valid, message_byte, byte_present, message_end, output ready);
endinterface

interface shb_out_if;
  import shb_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   digest_word;
  logic [WIDX_W-1:0]   word_number;
  logic                digest_done;

  modport source (output valid, digest_word, word_number, digest_done, input ready);
  modport sink   (input valid, digest_word, word_number, digest_done, output ready);
endinterface

>>> design/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream: byte packing, padding, iterative compression.
// Depends on shb_pkg, shb_if.sv and assert_macros.svh.
//
//  channel | dir | payload                                 | request
//  in_ch   | in  | message_byte, byte_present, message_end | one message byte or terminator
//  out_ch  | out | digest_word, word_number, digest_done   | one digest word, 8 per message
//
// Bytes are taken while idle; every 64th byte adds a compression: 64 rounds, one per
// cycle in the single round unit, then a fold step. The final request adds the
// padding bytes (up to 72), one or two compressions, then eight output requests.
// in_ch is held off during all of that.
// Reset (rst_n, synchronous) restores the initial hash and clears fill and length.
// out_ch stalls simply hold the current digest word.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_byte_stream_hasher (
  input  logic     clk,
  input  logic     rst_n,
  shb_in_if.sink   in_ch,
  shb_out_if.source out_ch
);
  import shb_pkg::*;

  shb_state_t             state_r, state_nxt;
  logic [BLOCK_W-1:0]     blk_r, blk_nxt;       // block buffer, doubles as schedule window
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [WORD_W-1:0]      hash_r [N_HASH];
  logic [WORD_W-1:0]      hash_nxt [N_HASH];
  logic [WORD_W-1:0]      v_r [N_HASH];
  logic [WORD_W-1:0]      v_nxt [N_HASH];
  logic [ROUND_W-1:0]     rnd_r, rnd_nxt;
  logic [WIDX_W-1:0]      word_r, word_nxt;
  logic                   pad_r, pad_nxt;             // padding owed after this block
  logic                   pad_first_r, pad_first_nxt; // next pad byte is the 0x80 mark
  logic                   len_ok_r, len_ok_nxt;       // this block may carry the length
  logic                   last_blk_r, last_blk_nxt;   // block in flight is the final one

  logic                   in_acc, out_acc;
  logic [WORD_W-1:0]      w_cur, w_new, t1, t2;
  logic [63:0]            len_bits;
  logic                   len_byte_sel;
  logic [BYTE_W-1:0]      pad_byte;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // Shared round unit and message schedule
  assign w_cur = blk_r[BLOCK_W-1 -: WORD_W];
  assign w_new = w_cur + sml_sig0(blk_r[BLOCK_W-1-WORD_W -: WORD_W])
               + blk_r[BLOCK_W-1-9*WORD_W -: WORD_W]
               + sml_sig1(blk_r[BLOCK_W-1-14*WORD_W -: WORD_W]);
  assign t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + round_k(rnd_r) + w_cur;
  assign t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // Padding byte source: mark, zeros, then bit length MSB first
  assign len_bits     = {len_r, 3'b000};
  assign len_byte_sel = !pad_first_r && len_ok_r && (fill_r >= LEN_START);
  assign pad_byte     = pad_first_r  ? PAD_MARK :
                        len_byte_sel ? len_bits[63:56] : '0;

  // Channel outputs
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = hash_r[word_r];
  assign out_ch.word_number = word_r;
  assign out_ch.digest_done = (word_r == WIDX_W'(N_HASH - 1));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    hash_nxt      = hash_r;
    v_nxt         = v_r;
    rnd_nxt       = rnd_r;
    word_nxt      = word_r;
    pad_nxt       = pad_r;
    pad_first_nxt = pad_first_r;
    len_ok_nxt    = len_ok_r;
    last_blk_nxt  = last_blk_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.byte_present) begin
            blk_nxt  = {blk_r[BLOCK_W-BYTE_W-1:0], in_ch.message_byte};
            fill_nxt = fill_r + 1'b1;
            len_nxt  = len_r + 1'b1;
          end
          if (in_ch.message_end) begin
            pad_nxt       = 1'b1;
            pad_first_nxt = 1'b1;
          end
          if (in_ch.byte_present && fill_r == '1) begin
            state_nxt    = S_ROUND;
            last_blk_nxt = 1'b0;
            v_nxt        = hash_r;
            rnd_nxt      = '0;
          end else if (in_ch.message_end) begin
            state_nxt = S_PAD;
          end
        end
      end

      S_PAD: begin
        blk_nxt       = {blk_r[BLOCK_W-BYTE_W-1:0], pad_byte};
        fill_nxt      = fill_r + 1'b1;
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          len_ok_nxt = (fill_r < LEN_START);
        end
        if (len_byte_sel) begin
          len_nxt = len_r << BYTE_W;
        end
        if (fill_r == '1) begin
          state_nxt    = S_ROUND;
          last_blk_nxt = len_byte_sel;
          v_nxt        = hash_r;
          rnd_nxt      = '0;
        end
      end

      S_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        blk_nxt  = {blk_r[BLOCK_W-WORD_W-1:0], w_new};
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == '1) begin
          state_nxt = S_FOLD;
        end
      end

      S_FOLD: begin
        for (int i = 0; i < N_HASH; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        if (last_blk_r) begin
          state_nxt = S_OUT;
          word_nxt  = '0;
        end else if (pad_r) begin
          // second padding block always carries the length
          state_nxt  = S_PAD;
          len_ok_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OUT: begin
        if (out_acc) begin
          word_nxt = word_r + 1'b1;
          if (word_r == WIDX_W'(N_HASH - 1)) begin
            state_nxt    = S_IDLE;
            fill_nxt     = '0;
            len_nxt      = '0;
            pad_nxt      = 1'b0;
            last_blk_nxt = 1'b0;
            for (int i = 0; i < N_HASH; i++) begin
              hash_nxt[i] = iv_word(WIDX_W'(i));
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      rnd_r       <= '0;
      word_r      <= '0;
      pad_r       <= 1'b0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
      last_blk_r  <= 1'b0;
      for (int i = 0; i < N_HASH; i++) begin
        hash_r[i] <= iv_word(WIDX_W'(i));
      end
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      rnd_r       <= rnd_nxt;
      word_r      <= word_nxt;
      pad_r       <= pad_nxt;
      pad_first_r <= pad_first_nxt;
      len_ok_r    <= len_ok_nxt;
      last_blk_r  <= last_blk_nxt;
      hash_r      <= hash_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    v_r   <= v_nxt;
  end

  // Checks
  `ASSERT_IMPL(a_no_overlap, out_ch.valid, !in_ch.ready, "input taken while digest pending")
  `ASSERT_NEXT(a_round_end, state_r == S_ROUND && rnd_r == '1, state_r == S_FOLD, "round slip")
  `ASSERT_NEXT(a_restart, out_acc && out_ch.digest_done, fill_r == '0 && len_r == '0, "no restart")

endmodule
